### design/angle_slew_limiter_with_direction_macros.svh
`ifndef ANGLE_SLEW_LIMITER_WITH_DIRECTION_MACROS_SVH
`define ANGLE_SLEW_LIMITER_WITH_DIRECTION_MACROS_SVH

// same-cycle implication
`define ASL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asl check failed");

// next-cycle implication
`define ASL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asl check failed");

`endif

### design/asl_pkg.sv
`timescale 1ns / 1ps

package asl_pkg;

   localparam int AngleW = 16;
   localparam int StepW  = 15;
   localparam int ModeW  = 2;
   localparam int WideW  = 18;

   localparam logic signed [WideW-1:0] HALF_TURN = 18'sd18000;
   localparam logic signed [WideW-1:0] FULL_TURN = 18'sd36000;
   localparam logic signed [AngleW-1:0] HALF_TURN_A = 16'sd18000;
   localparam logic [StepW-1:0] STEP_RESET = 15'd100;

   localparam logic [ModeW-1:0] MODE_SHORTEST = 2'd0;
   localparam logic [ModeW-1:0] MODE_CW       = 2'd1;
   localparam logic [ModeW-1:0] MODE_CCW      = 2'd2;

   typedef struct packed {
      logic signed [AngleW-1:0] target;
      logic signed [AngleW-1:0] measured;
      logic [ModeW-1:0]         mode;
   } item_type;

   function automatic logic signed [AngleW-1:0] clamp_angle(
      input logic signed [AngleW-1:0] a
   );
      logic signed [AngleW-1:0] r;
      r = a;
      if (a > HALF_TURN_A) begin
         r = HALF_TURN_A;
      end else if (a < -HALF_TURN_A) begin
         r = -HALF_TURN_A;
      end
      return r;
   endfunction

   // nonnegative remainder for x in [-36000, 36000]
   function automatic logic signed [WideW-1:0] pos_mod_turn(
      input logic signed [WideW-1:0] x
   );
      logic signed [WideW-1:0] r;
      r = x;
      if (x < 0) begin
         r = x + FULL_TURN;
      end else if (x >= FULL_TURN) begin
         r = x - FULL_TURN;
      end
      return r;
   endfunction

endpackage

### design/asl_step.sv
`timescale 1ns / 1ps

module asl_step (
   input  asl_pkg::item_type                 item,
   input  logic                              started,
   input  logic signed [asl_pkg::AngleW-1:0] setpoint,
   input  logic [asl_pkg::StepW-1:0]         step_limit,
   output logic signed [asl_pkg::AngleW-1:0] next_setpoint
);
   import asl_pkg::*;

   logic signed [AngleW-1:0] cur;
   logic signed [WideW-1:0]  s_w;
   logic signed [WideW-1:0]  t_w;
   logic signed [WideW-1:0]  d_ts;
   logic signed [WideW-1:0]  d_st;
   logic signed [WideW-1:0]  err;
   logic signed [WideW-1:0]  mag;
   logic signed [WideW-1:0]  step_w;
   logic signed [WideW-1:0]  moved;
   logic signed [WideW-1:0]  wrapped;

   always_comb begin
      cur    = started ? setpoint : item.measured;
      s_w    = WideW'(cur);
      t_w    = WideW'(item.target);
      d_ts   = t_w - s_w;
      d_st   = s_w - t_w;
      step_w = signed'({{(WideW-StepW){1'b0}}, step_limit});

      case (item.mode)
         MODE_SHORTEST: begin
            err = d_ts;
            if (d_ts > HALF_TURN) begin
               err = d_ts - FULL_TURN;
            end else if (d_ts < -HALF_TURN) begin
               err = d_ts + FULL_TURN;
            end
         end
         MODE_CW: begin
            err = -pos_mod_turn(d_st);
         end
         default: begin
            err = pos_mod_turn(d_ts);
         end
      endcase

      mag = (err < 0) ? -err : err;
      if (mag <= step_w) begin
         moved = t_w;
      end else if (err > 0) begin
         moved = s_w + step_w;
      end else begin
         moved = s_w - step_w;
      end

      wrapped = moved;
      if (moved > HALF_TURN) begin
         wrapped = moved - FULL_TURN;
      end else if (moved < -HALF_TURN) begin
         wrapped = moved + FULL_TURN;
      end

      next_setpoint = wrapped[AngleW-1:0];
   end

endmodule

### design/angle_slew_limiter_with_direction.sv
`timescale 1ns / 1ps
// Heading slew limiter. Each req beat carries target, measured heading and
// a direction mode; each one yields exactly one rsp beat with the new
// setpoint, via the input and then the result register. One beat per cycle
// is sustained while rsp_tready is high; the setpoint loop closes through
// the step unit between those registers. The first beat after reset seeds
// the setpoint from the measured heading. The user must write step_limit
// through the csr port while no beat is in flight; it is not enforced.

`include "angle_slew_limiter_with_direction_macros.svh"

module angle_slew_limiter_with_direction (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] target_angle, [31:16] measured_angle, [33:32] direction_mode
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] setpoint_angle
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [asl_pkg::StepW-1:0] csr_data
);
   import asl_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   item_type                 s1_item_ff, s1_item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [AngleW-1:0] rsp_data_ff, rsp_data_in;
   logic signed [AngleW-1:0] setpoint_ff, setpoint_in;
   logic                     started_ff, started_in;
   logic [StepW-1:0]         step_ff, step_in;
   logic signed [AngleW-1:0] next_sp;
   logic                     req_beat;
   logic                     advance;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   asl_step u_step (
      .item          (s1_item_ff),
      .started       (started_ff),
      .setpoint      (setpoint_ff),
      .step_limit    (step_ff),
      .next_setpoint (next_sp)
   );

   always_comb begin
      s1_item_in.target   = clamp_angle(req_tdata[15:0]);
      s1_item_in.measured = clamp_angle(req_tdata[31:16]);
      s1_item_in.mode     = req_tdata[33:32];

      s1_valid_in = req_beat ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = advance ? next_sp : rsp_data_ff;
      setpoint_in  = advance ? next_sp : setpoint_ff;
      started_in   = advance ? 1'b1 : started_ff;
      step_in      = (csr_valid && csr_ready) ? csr_data : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         setpoint_ff  <= '0;
         started_ff   <= 1'b0;
         step_ff      <= STEP_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         setpoint_ff  <= setpoint_in;
         started_ff   <= started_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_item_ff <= s1_item_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   `ASL_ASSERT_NOW(a_sp_range, clock, reset, started_ff, (setpoint_ff <= HALF_TURN_A) && (setpoint_ff >= -HALF_TURN_A))
   `ASL_ASSERT_NOW(a_rsp_tracks_sp, clock, reset, started_ff, rsp_data_ff == setpoint_ff)
   `ASL_ASSERT_NOW(a_no_rsp_before_start, clock, reset, !started_ff, !rsp_valid_ff)
   `ASL_ASSERT_NEXT(a_sp_hold_on_stall, clock, reset, !advance, $stable(setpoint_ff))
   `ASL_ASSERT_NEXT(a_started_after_adv, clock, reset, advance, started_ff && rsp_valid_ff)

endmodule

### tb/angle_slew_limiter_with_direction_tb.sv
`timescale 1ns / 1ps

module angle_slew_limiter_with_direction_tb;
   import asl_pkg::*;

   localparam int QuietLimit = 3000;
   localparam int BlockLen   = 60;

   class heading_scoreboard;
      int unsigned step_limit;
      int          setpoint;
      bit          started;
      logic [15:0] expected_setpoints[$];
      int          errors;

      function new();
         step_limit = STEP_RESET;
         setpoint   = 0;
         started    = 1'b0;
         errors     = 0;
      endfunction

      static function int clamp_heading(logic [15:0] raw);
         int v;
         v = int'($signed(raw));
         if (v > 18000) v = 18000;
         if (v < -18000) v = -18000;
         return v;
      endfunction

      static function int turn_remainder(int x);
         int r;
         r = x % 36000;
         if (r < 0) r += 36000;
         return r;
      endfunction

      function void note_item(logic [15:0] tgt_raw, logic [15:0] meas_raw,
                              logic [ModeW-1:0] mode);
         int tgt;
         int err;
         int mag;
         int stepv;
         tgt   = clamp_heading(tgt_raw);
         stepv = int'(step_limit);
         if (!started) begin
            setpoint = clamp_heading(meas_raw);
            started  = 1'b1;
         end
         if (mode == MODE_SHORTEST) begin
            err = tgt - setpoint;
            if (err > 18000) err -= 36000;
            else if (err < -18000) err += 36000;
         end else if (mode == MODE_CW) begin
            err = -turn_remainder(setpoint - tgt);
         end else begin
            err = turn_remainder(tgt - setpoint);
         end
         mag = (err < 0) ? -err : err;
         if (mag <= stepv) setpoint = tgt;
         else setpoint += (err > 0) ? stepv : -stepv;
         if (setpoint > 18000) setpoint -= 36000;
         if (setpoint < -18000) setpoint += 36000;
         expected_setpoints.push_back(16'(setpoint));
      endfunction

      task report_mismatch(string msg);
         if (errors < 200) $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_setpoint(logic [15:0] got);
         logic [15:0] want;
         if (expected_setpoints.size() == 0) begin
            report_mismatch($sformatf("setpoint %0d with none pending", $signed(got)));
         end else begin
            want = expected_setpoints.pop_front();
            if (got !== want)
               report_mismatch($sformatf("setpoint_angle got %0d want %0d",
                                         $signed(got), $signed(want)));
         end
      endtask

      function int pending();
         return expected_setpoints.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [39:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;
   logic              csr_valid;
   logic              csr_ready;
   logic [StepW-1:0]  csr_data;

   heading_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left = 0;

   angle_slew_limiter_with_direction dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_setpoint(rsp_tdata);
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("angle_slew_limiter_with_direction test failed");
      $finish;
   end

   task automatic send_heading(logic [15:0] tgt, logic [15:0] meas, logic [ModeW-1:0] mode);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, mode, meas, tgt};
      do @(posedge clock); while (!req_tready);
      sb.note_item(tgt, meas, mode);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_step(int unsigned value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= StepW'(value);
      do @(posedge clock); while (!csr_ready);
      sb.step_limit = value & 32'h7fff;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_heading();
      case ($urandom_range(0, 19))
         0: return 16'(-18000);
         1: return 16'(18000);
         2: return 16'($urandom);
         3: return 16'(sb.setpoint + int'($urandom_range(0, 600)) - 300);
         default: return 16'(int'($urandom_range(0, 36000)) - 18000);
      endcase
   endfunction

   function automatic logic [ModeW-1:0] random_mode();
      int r;
      r = $urandom_range(0, 9);
      return (r < 9) ? ModeW'(r / 3) : ModeW'(3);
   endfunction

   function automatic int unsigned random_step();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 18000;
         2: return 32767;
         3: return 1;
         4, 5, 6: return $urandom_range(2, 300);
         7, 8: return $urandom_range(301, 18000);
         default: return $urandom_range(18001, 32767);
      endcase
   endfunction

   // mostly held targets so the setpoint walks in and lands, plus single noise beats
   task automatic run_block(int n);
      int sent;
      int run_len;
      logic [15:0] tgt;
      logic [ModeW-1:0] mode;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 9) < 7) run_len = $urandom_range(2, 12);
         else run_len = 1;
         if (run_len > n - sent) run_len = n - sent;
         tgt  = random_heading();
         mode = random_mode();
         repeat (run_len) send_heading(tgt, 16'($urandom), mode);
         sent += run_len;
      end
   endtask

   task automatic run_phase(int items, bit with_stall);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         n = (items - sent < BlockLen) ? items - sent : BlockLen;
         write_step(random_step());
         if (with_stall && sent == BlockLen) stall_left = 400;
         run_block(n);
         sent += n;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset step, first beat seeds from a saturated measured heading
      send_heading(16'd0, 16'h8000, MODE_SHORTEST);
      send_heading(16'(18000), 16'h7fff, MODE_SHORTEST);
      send_heading(16'h7fff, 16'h0000, MODE_CW);
      send_heading(16'h8000, 16'hffff, MODE_CCW);
      send_heading(16'(-18000), 16'h1234, ModeW'(3));
      send_heading(16'(-17950), 16'h0000, MODE_SHORTEST);
      send_heading(16'(sb.setpoint), 16'h0000, MODE_CW);

      write_step(0);
      send_heading(16'(12345), 16'h0000, MODE_SHORTEST);
      send_heading(16'(sb.setpoint), 16'h0000, MODE_SHORTEST);
      send_heading(16'(sb.setpoint), 16'h0000, MODE_CW);
      send_heading(16'(sb.setpoint), 16'h0000, MODE_CCW);
      send_heading(16'(-sb.setpoint), 16'h0000, MODE_SHORTEST);

      write_step(18000);
      send_heading(16'(sb.setpoint + 1), 16'h0000, MODE_CW);
      send_heading(16'(sb.setpoint - 1), 16'h0000, MODE_CCW);
      send_heading(16'(0), 16'h0000, MODE_SHORTEST);
      send_heading(16'(18000), 16'h0000, MODE_SHORTEST);
      send_heading(16'(-18000), 16'h0000, MODE_CCW);

      write_step(32767);
      send_heading(16'(sb.setpoint - 1), 16'h0000, MODE_CCW);
      send_heading(16'(sb.setpoint + 1), 16'h0000, MODE_CW);
      send_heading(16'(-9000), 16'h0000, ModeW'(3));
      send_heading(16'(9000), 16'h0000, MODE_SHORTEST);

      write_step(1);
      send_heading(16'(sb.setpoint + 2), 16'h0000, MODE_SHORTEST);
      send_heading(16'(sb.setpoint - 1), 16'h0000, MODE_SHORTEST);

      send_idle_pct = 36;
      recv_idle_pct = 87;
      run_phase(490, 1'b0);
      send_idle_pct = 87;
      recv_idle_pct = 36;
      run_phase(480, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(480, 1'b1);

      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("angle_slew_limiter_with_direction test passed");
      else
         $display("angle_slew_limiter_with_direction test failed");
      $finish;
   end

endmodule
